// File: rtl/assert_macros.svh
// assertion macros shared by the source mapper rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked on every clock edge outside reset
`define MCSM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// consequent checked in the same cycle as the antecedent
`define MCSM_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define MCSM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/mcsm_pkg.sv
// shared types and constants of the midi controller source mapper
`default_nettype none

package mcsm_pkg;

   // poly aftertouch slot store
   localparam int NOTE_SLOTS = 128;
   localparam int SLOT_W     = (NOTE_SLOTS > 1) ? $clog2(NOTE_SLOTS) : 1;

   // request queue between front and back
   localparam int FIFO_DEPTH = 2;
   localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

   // source codes and level constants
   localparam logic [7:0]  SRC_PRESSURE = 8'd128;
   localparam logic [7:0]  SRC_PITCH    = 8'd129;
   localparam logic [7:0]  SRC_RESET    = 8'd1;
   localparam logic [16:0] LEVEL_ONE    = 17'd65536;
   localparam logic [6:0]  DATA7_MAX    = 7'd127;

   // event op codes on the request port
   typedef enum logic [2:0] {
      OP_CONTROLLER = 3'd0,
      OP_PRESSURE   = 3'd1,
      OP_POLY       = 3'd2,
      OP_PITCH      = 3'd3,
      OP_NOTE_OFF   = 3'd4,
      OP_OTHER      = 3'd5
   } op_type;

   // classified event kinds handed to the back end
   typedef enum logic [2:0] {
      KIND_CONTROLLER,
      KIND_PRESSURE,
      KIND_POLY,
      KIND_PITCH,
      KIND_NOTE_OFF,
      KIND_NONE
   } kind_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_SOURCE_SELECT  = 2'd0,
      CSR_INVERT_OUTPUT  = 2'd1,
      CSR_LEARN_ON_START = 2'd2
   } csr_index_type;

   // one classified request; data is already saturated for 7-bit events
   typedef struct packed {
      kind_type    kind;
      logic [6:0]  number;
      logic [13:0] data;
   } item_type;

   // head of the request queue as seen by the back end
   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_type;

   // configuration write
   typedef struct packed {
      logic          we;
      csr_index_type index;
      logic [7:0]    wdata;
   } csr_write_type;

endpackage

`default_nettype wire

// File: rtl/mcsm_front.sv
// front end: classifies incoming requests and queues them for the back end
`default_nettype none
`include "assert_macros.svh"

module mcsm_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   output logic                     full,
   input  wire logic [2:0]          op,
   input  wire logic [6:0]          number,
   input  wire logic [13:0]         value,
   output mcsm_pkg::queue_type      q_out,
   input  wire logic                q_pop
);

   mcsm_pkg::item_type                 fifo_ff [mcsm_pkg::FIFO_DEPTH];
   logic [mcsm_pkg::PTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [mcsm_pkg::PTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [mcsm_pkg::CNT_W-1:0]         count_ff, count_in;
   mcsm_pkg::item_type                 item_cls;
   logic                               push_ok;
   logic                               pop_ok;

   // classify the op and saturate 7-bit data values
   always_comb begin
      item_cls.number = number;
      item_cls.data   = value;
      unique case (mcsm_pkg::op_type'(op))
         mcsm_pkg::OP_CONTROLLER: item_cls.kind = mcsm_pkg::KIND_CONTROLLER;
         mcsm_pkg::OP_PRESSURE:   item_cls.kind = mcsm_pkg::KIND_PRESSURE;
         mcsm_pkg::OP_POLY:       item_cls.kind = mcsm_pkg::KIND_POLY;
         mcsm_pkg::OP_PITCH:      item_cls.kind = mcsm_pkg::KIND_PITCH;
         mcsm_pkg::OP_NOTE_OFF:   item_cls.kind = mcsm_pkg::KIND_NOTE_OFF;
         mcsm_pkg::OP_OTHER:      item_cls.kind = mcsm_pkg::KIND_NONE;
         default:                 item_cls.kind = mcsm_pkg::KIND_NONE;
      endcase
      if (item_cls.kind != mcsm_pkg::KIND_PITCH && value > 14'(mcsm_pkg::DATA7_MAX)) begin
         item_cls.data = 14'(mcsm_pkg::DATA7_MAX);
      end
   end

   // queue handshake
   assign full         = (count_ff == mcsm_pkg::CNT_W'(mcsm_pkg::FIFO_DEPTH));
   assign push_ok      = push && !full;
   assign q_out.valid  = (count_ff != '0);
   assign q_out.item   = fifo_ff[rd_ptr_ff];
   assign pop_ok       = q_pop && q_out.valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push_ok) begin
         if (wr_ptr_ff == mcsm_pkg::PTR_W'(mcsm_pkg::FIFO_DEPTH - 1)) begin
            wr_ptr_in = '0;
         end else begin
            wr_ptr_in = wr_ptr_ff + mcsm_pkg::PTR_W'(1);
         end
      end
      if (pop_ok) begin
         if (rd_ptr_ff == mcsm_pkg::PTR_W'(mcsm_pkg::FIFO_DEPTH - 1)) begin
            rd_ptr_in = '0;
         end else begin
            rd_ptr_in = rd_ptr_ff + mcsm_pkg::PTR_W'(1);
         end
      end
      count_in = count_ff + mcsm_pkg::CNT_W'(push_ok) - mcsm_pkg::CNT_W'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push_ok) begin
         fifo_ff[wr_ptr_ff] <= item_cls;
      end
   end

   `MCSM_ASSERT(a_count_bound, count_ff <= mcsm_pkg::CNT_W'(mcsm_pkg::FIFO_DEPTH), "queue overfilled")
   `MCSM_ASSERT_NEXT(a_count_up, push_ok && !pop_ok, count_ff == $past(count_ff) + mcsm_pkg::CNT_W'(1), "count missed a request")
   `MCSM_ASSERT_NEXT(a_count_down, pop_ok && !push_ok, count_ff == $past(count_ff) - mcsm_pkg::CNT_W'(1), "count missed a pop")

endmodule

`default_nettype wire

// File: rtl/mcsm_back.sv
// back end: source state, learn, aftertouch slot scan, scaling and result register
`default_nettype none
`include "assert_macros.svh"

module mcsm_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire mcsm_pkg::csr_write_type csr,
   input  wire mcsm_pkg::queue_type    q_in,
   output logic                        q_pop,
   output logic                        out_empty,
   input  wire logic                   out_pop,
   output logic [16:0]                 target_level,
   output logic                        target_changed,
   output logic [7:0]                  active_source
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_EMIT
   } state_type;

   localparam logic [mcsm_pkg::SLOT_W:0] SCAN_END = (mcsm_pkg::SLOT_W + 1)'(mcsm_pkg::NOTE_SLOTS);

   // floor(v * 65536 / 127): 65536 = 127 * 516 + 4
   function automatic logic [16:0] scale7(input logic [6:0] v);
      logic [16:0] base;
      logic [8:0]  v4;
      logic [2:0]  corr;
      base = 17'(v) * 17'd516;
      v4   = {v, 2'b00};
      corr = {2'b00, v4 >= 9'd127} + {2'b00, v4 >= 9'd254}
           + {2'b00, v4 >= 9'd381} + {2'b00, v4 >= 9'd508};
      return base + 17'(corr);
   endfunction

   // floor(v * 65536 / 16383): 65536 = 16383 * 4 + 4
   function automatic logic [16:0] scale14(input logic [13:0] v);
      logic [15:0] v4;
      logic [2:0]  corr;
      v4   = {v, 2'b00};
      corr = {2'b00, v4 >= 16'd16383} + {2'b00, v4 >= 16'd32766}
           + {2'b00, v4 >= 16'd49149} + {2'b00, v4 >= 16'd65532};
      return 17'(v4) + 17'(corr);
   endfunction

   state_type                       state_ff, state_in;
   logic [7:0]                      source_now_ff, source_now_in;
   logic                            learning_ff, learning_in;
   logic                            invert_ff, invert_in;
   logic [16:0]                     level_ff, level_in;
   logic                            changed_ff, changed_in;
   logic [mcsm_pkg::NOTE_SLOTS-1:0] slot_valid_ff, slot_valid_in;
   logic [mcsm_pkg::SLOT_W:0]       scan_ff, scan_in;
   logic                            rd_live_ff, rd_live_in;
   logic                            rd_valid_ff, rd_valid_in;
   logic [6:0]                      best_ff, best_in;
   logic                            any_ff, any_in;
   logic                            out_full_ff, out_full_in;
   logic [16:0]                     out_level_ff, out_level_in;
   logic                            out_changed_ff, out_changed_in;
   logic [7:0]                      out_source_ff, out_source_in;

   logic [6:0]                      slot_mem [mcsm_pkg::NOTE_SLOTS];
   logic [6:0]                      rd_data_ff;
   logic                            mem_we;
   logic                            rd_en;

   mcsm_pkg::item_type              item;
   logic                            event_kind;
   logic [7:0]                      learn_src;
   logic [7:0]                      src_eff;
   logic                            match;
   logic                            in_range;
   logic [mcsm_pkg::SLOT_W-1:0]     note_idx;
   logic [mcsm_pkg::SLOT_W-1:0]     scan_idx;
   logic [16:0]                     direct_lvl;
   logic [16:0]                     poly_lvl;

   // decode of the queue head
   assign item     = q_in.item;
   assign note_idx = item.number[mcsm_pkg::SLOT_W-1:0];
   assign scan_idx = scan_ff[mcsm_pkg::SLOT_W-1:0];
   assign in_range = ({1'b0, item.number} < 8'(mcsm_pkg::NOTE_SLOTS));

   assign event_kind = (item.kind == mcsm_pkg::KIND_CONTROLLER)
                    || (item.kind == mcsm_pkg::KIND_PRESSURE)
                    || (item.kind == mcsm_pkg::KIND_POLY)
                    || (item.kind == mcsm_pkg::KIND_PITCH);

   // source captured by learn mode
   always_comb begin
      unique case (item.kind)
         mcsm_pkg::KIND_CONTROLLER: learn_src = {1'b0, item.number};
         mcsm_pkg::KIND_PITCH:      learn_src = mcsm_pkg::SRC_PITCH;
         default:                   learn_src = mcsm_pkg::SRC_PRESSURE;
      endcase
   end

   assign src_eff = (learning_ff && event_kind) ? learn_src : source_now_ff;

   assign match = ((item.kind == mcsm_pkg::KIND_CONTROLLER) && (src_eff == {1'b0, item.number}))
               || ((src_eff == mcsm_pkg::SRC_PRESSURE)
                   && ((item.kind == mcsm_pkg::KIND_PRESSURE) || (item.kind == mcsm_pkg::KIND_POLY)))
               || ((src_eff == mcsm_pkg::SRC_PITCH) && (item.kind == mcsm_pkg::KIND_PITCH));

   // level of a direct event and of the finished slot scan
   assign direct_lvl = (item.kind == mcsm_pkg::KIND_PITCH) ? scale14(item.data)
                                                           : scale7(item.data[6:0]);
   assign poly_lvl   = any_ff ? scale7(best_ff) : 17'd0;

   // sequencer
   always_comb begin
      state_in       = state_ff;
      source_now_in  = source_now_ff;
      learning_in    = learning_ff;
      invert_in      = invert_ff;
      level_in       = level_ff;
      changed_in     = changed_ff;
      slot_valid_in  = slot_valid_ff;
      scan_in        = scan_ff;
      rd_live_in     = rd_live_ff;
      rd_valid_in    = rd_valid_ff;
      best_in        = best_ff;
      any_in         = any_ff;
      out_full_in    = out_full_ff;
      out_level_in   = out_level_ff;
      out_changed_in = out_changed_ff;
      out_source_in  = out_source_ff;
      q_pop          = 1'b0;
      mem_we         = 1'b0;
      rd_en          = 1'b0;

      if (out_pop) begin
         out_full_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (q_in.valid) begin
               q_pop      = 1'b1;
               changed_in = 1'b0;
               state_in   = S_EMIT;
               unique case (item.kind)
                  mcsm_pkg::KIND_NOTE_OFF: begin
                     if (in_range) begin
                        slot_valid_in[note_idx] = 1'b0;
                     end
                  end
                  mcsm_pkg::KIND_NONE: begin
                  end
                  default: begin
                     learning_in   = 1'b0;
                     source_now_in = src_eff;
                     if (match && item.kind == mcsm_pkg::KIND_POLY) begin
                        // store the note, then scan all slots for the maximum
                        if (in_range) begin
                           mem_we                  = 1'b1;
                           slot_valid_in[note_idx] = 1'b1;
                        end
                        scan_in    = '0;
                        best_in    = '0;
                        any_in     = 1'b0;
                        rd_live_in = 1'b0;
                        state_in   = S_SCAN;
                     end else if (match) begin
                        level_in   = invert_ff ? (mcsm_pkg::LEVEL_ONE - direct_lvl) : direct_lvl;
                        changed_in = 1'b1;
                     end
                  end
               endcase
            end
         end

         S_SCAN: begin
            // fold in the slot read last cycle
            if (rd_live_ff && rd_valid_ff) begin
               if (!any_ff || rd_data_ff > best_ff) begin
                  best_in = rd_data_ff;
               end
               any_in = 1'b1;
            end
            if (scan_ff < SCAN_END) begin
               rd_en       = 1'b1;
               rd_live_in  = 1'b1;
               rd_valid_in = slot_valid_ff[scan_idx];
               scan_in     = scan_ff + (mcsm_pkg::SLOT_W + 1)'(1);
            end else begin
               rd_live_in = 1'b0;
               if (!rd_live_ff) begin
                  level_in   = invert_ff ? (mcsm_pkg::LEVEL_ONE - poly_lvl) : poly_lvl;
                  changed_in = 1'b1;
                  state_in   = S_EMIT;
               end
            end
         end

         S_EMIT: begin
            if (!out_full_ff || out_pop) begin
               out_full_in    = 1'b1;
               out_level_in   = level_ff;
               out_changed_in = changed_ff;
               out_source_in  = source_now_ff;
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // configuration writes
      if (csr.we) begin
         unique case (csr.index)
            mcsm_pkg::CSR_SOURCE_SELECT:  source_now_in = csr.wdata;
            mcsm_pkg::CSR_INVERT_OUTPUT:  invert_in     = csr.wdata[0];
            mcsm_pkg::CSR_LEARN_ON_START: learning_in   = csr.wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         source_now_ff <= mcsm_pkg::SRC_RESET;
         learning_ff   <= 1'b0;
         invert_ff     <= 1'b0;
         level_ff      <= mcsm_pkg::LEVEL_ONE;
         slot_valid_ff <= '0;
         rd_live_ff    <= 1'b0;
         any_ff        <= 1'b0;
         out_full_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         source_now_ff <= source_now_in;
         learning_ff   <= learning_in;
         invert_ff     <= invert_in;
         level_ff      <= level_in;
         slot_valid_ff <= slot_valid_in;
         rd_live_ff    <= rd_live_in;
         any_ff        <= any_in;
         out_full_ff   <= out_full_in;
      end
      changed_ff     <= changed_in;
      scan_ff        <= scan_in;
      rd_valid_ff    <= rd_valid_in;
      best_ff        <= best_in;
      out_level_ff   <= out_level_in;
      out_changed_ff <= out_changed_in;
      out_source_ff  <= out_source_in;
   end

   // slot store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[note_idx] <= item.data[6:0];
      end
      if (rd_en) begin
         rd_data_ff <= slot_mem[scan_idx];
      end
   end

   // result ports
   assign out_empty      = !out_full_ff;
   assign target_level   = out_level_ff;
   assign target_changed = out_changed_ff;
   assign active_source  = out_source_ff;

   `MCSM_ASSERT(a_scan_bound, scan_ff <= SCAN_END || state_ff != S_SCAN, "slot scan ran past the store")
   `MCSM_ASSERT_NEXT(a_learn_ends, state_ff == S_IDLE && q_in.valid && event_kind && !csr.we, !learning_ff, "learn mode survived an event")
   `MCSM_ASSERT_IMPL(a_level_range, out_full_ff, out_level_ff <= mcsm_pkg::LEVEL_ONE, "level above one")

endmodule

`default_nettype wire

// File: rtl/midi_controller_source_mapper.sv
// top level of the midi controller source mapper
`default_nettype none

// Maps one selected MIDI source (controller 0-127, 128 for channel pressure or
// poly aftertouch, 129 for pitch wheel) to a Q1.16 target level and returns one
// result per request with the level, a changed flag and the source in effect.
// A two-entry request queue decouples the request port from the back end, and
// a result register decouples the back end from the result port. Each request
// passes through the idle and emit states of the back end, except a matching
// poly aftertouch request, which first scans every slot of the aftertouch store
// in the scan state. Requests are worked one at a time. Slot occupancy lives
// in per-slot flags that reset clears at once, so there is no clearing pass
// after reset. Configuration writes are meant for an idle block: no request
// outstanding and no result waiting.
module midi_controller_source_mapper (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [2:0]  req_op,
   input  wire logic [6:0]  req_number,
   input  wire logic [13:0] req_value,
   output logic             empty,
   input  wire logic        pop,
   output logic [16:0]      rsp_target_level,
   output logic             rsp_target_changed,
   output logic [7:0]       rsp_active_source,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_wdata
);

   mcsm_pkg::queue_type     queue_head;
   logic                    queue_pop;
   mcsm_pkg::csr_write_type csr;

   // configuration write bundle
   assign csr.we    = csr_we;
   assign csr.index = mcsm_pkg::csr_index_type'(csr_index);
   assign csr.wdata = csr_wdata;

   // request classification and queue
   mcsm_front u_front (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .full   (full),
      .op     (req_op),
      .number (req_number),
      .value  (req_value),
      .q_out  (queue_head),
      .q_pop  (queue_pop)
   );

   // source state, slot scan and result register
   mcsm_back u_back (
      .clock          (clock),
      .reset          (reset),
      .csr            (csr),
      .q_in           (queue_head),
      .q_pop          (queue_pop),
      .out_empty      (empty),
      .out_pop        (pop),
      .target_level   (rsp_target_level),
      .target_changed (rsp_target_changed),
      .active_source  (rsp_active_source)
   );

endmodule

`default_nettype wire

// File: bench/tb_midi_controller_source_mapper.sv
// testbench for the midi controller source mapper: random events checked against a level predictor
module tb_midi_controller_source_mapper;

   localparam logic [2:0] OP_UNUSED_A   = 3'd6;
   localparam logic [2:0] OP_UNUSED_B   = 3'd7;
   localparam logic [7:0] SLOT_EMPTY    = 8'd255;
   localparam int         RANDOM_EVENTS = 800;
   localparam int         QUIET_FROM    = 700;
   localparam int         LATENCY_CYCLES = 140;
   localparam int         CYCLE_LIMIT   = 1000000;
   localparam int         REPORT_LIMIT  = 10;

   // one expected response of the mapper
   typedef struct {
      logic [16:0] level;
      logic        changed;
      logic [7:0]  source;
   } level_result_type;

   // predicts the target level and checks responses in order
   class level_scoreboard_type;
      logic [7:0]       slot_value [mcsm_pkg::NOTE_SLOTS];
      logic [7:0]       source_now;
      bit               learning;
      bit               invert;
      logic [16:0]      level_now;
      level_result_type expected_levels [$];
      int               mismatches;

      function new();
         foreach (slot_value[i]) slot_value[i] = SLOT_EMPTY;
         source_now = mcsm_pkg::SRC_RESET;
         learning   = 1'b0;
         invert     = 1'b0;
         level_now  = mcsm_pkg::LEVEL_ONE;
         mismatches = 0;
      endfunction

      function logic [16:0] scale_data7(logic [13:0] v);
         logic [31:0] d;
         d = (v > 14'd127) ? 32'd127 : 32'(v);
         return 17'((d * 32'd65536) / 32'd127);
      endfunction

      function logic [16:0] scale_pitch(logic [13:0] v);
         return 17'((32'(v) * 32'd65536) / 32'd16383);
      endfunction

      function void write_reg(mcsm_pkg::csr_index_type idx, logic [7:0] data);
         case (idx)
            mcsm_pkg::CSR_SOURCE_SELECT:  source_now = data;
            mcsm_pkg::CSR_INVERT_OUTPUT:  invert = data[0];
            mcsm_pkg::CSR_LEARN_ON_START: learning = data[0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_levels.size();
      endfunction

      // accepted request: update the predicted state and queue the response
      function void note_request(logic [2:0] op, logic [6:0] num, logic [13:0] val);
         level_result_type res;
         logic             match;
         logic [16:0]      lvl;
         logic [7:0]       best;
         bit               any_held;
         res.changed = 1'b0;
         if (op == mcsm_pkg::OP_NOTE_OFF) begin
            if (int'(num) < mcsm_pkg::NOTE_SLOTS) slot_value[num] = SLOT_EMPTY;
         end else if (op <= mcsm_pkg::OP_PITCH) begin
            // learn takes the source from the first source-like event
            if (learning) begin
               if (op == mcsm_pkg::OP_CONTROLLER) source_now = {1'b0, num};
               else if (op == mcsm_pkg::OP_PITCH) source_now = mcsm_pkg::SRC_PITCH;
               else source_now = mcsm_pkg::SRC_PRESSURE;
               learning = 1'b0;
            end
            match = (op == mcsm_pkg::OP_CONTROLLER && {1'b0, num} == source_now) ||
                    (source_now == mcsm_pkg::SRC_PRESSURE &&
                     (op == mcsm_pkg::OP_PRESSURE || op == mcsm_pkg::OP_POLY)) ||
                    (source_now == mcsm_pkg::SRC_PITCH && op == mcsm_pkg::OP_PITCH);
            if (match) begin
               if (op == mcsm_pkg::OP_CONTROLLER || op == mcsm_pkg::OP_PRESSURE) begin
                  lvl = scale_data7(val);
               end else if (op == mcsm_pkg::OP_PITCH) begin
                  lvl = scale_pitch(val);
               end else begin
                  // poly aftertouch: store the note, then take the max of held slots
                  if (int'(num) < mcsm_pkg::NOTE_SLOTS)
                     slot_value[num] = (val > 14'd127) ? 8'd127 : val[7:0];
                  best = 8'd0;
                  any_held = 1'b0;
                  foreach (slot_value[i]) begin
                     if (slot_value[i] != SLOT_EMPTY) begin
                        if (!any_held || slot_value[i] > best) best = slot_value[i];
                        any_held = 1'b1;
                     end
                  end
                  lvl = any_held ? scale_data7({6'd0, best}) : 17'd0;
               end
               if (invert) lvl = mcsm_pkg::LEVEL_ONE - lvl;
               level_now   = lvl;
               res.changed = 1'b1;
            end
         end
         res.level  = level_now;
         res.source = source_now;
         expected_levels.push_back(res);
      endfunction

      // accepted response: compare with the oldest expectation
      function void check_result(logic [16:0] level, logic changed, logic [7:0] source);
         level_result_type exp_res;
         if (expected_levels.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected response: level %0d changed %0d source %0d",
                        level, changed, source);
            return;
         end
         exp_res = expected_levels.pop_front();
         if (exp_res.level !== level || exp_res.changed !== changed ||
             exp_res.source !== source) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("mismatch: level %0d/%0d changed %0d/%0d source %0d/%0d (exp/act)",
                        exp_res.level, level, exp_res.changed, changed,
                        exp_res.source, source);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [2:0]  req_op = mcsm_pkg::OP_OTHER;
   logic [6:0]  req_number = 7'd0;
   logic [13:0] req_value = 14'd0;
   logic        empty;
   logic        pop = 1'b0;
   logic [16:0] rsp_target_level;
   logic        rsp_target_changed;
   logic [7:0]  rsp_active_source;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = mcsm_pkg::CSR_SOURCE_SELECT;
   logic [7:0]  csr_wdata = 8'd0;

   bit                   allow_idle = 1'b1;
   int                   cycle_count = 0;
   level_scoreboard_type sb = new();

   midi_controller_source_mapper u_dut (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_op             (req_op),
      .req_number         (req_number),
      .req_value          (req_value),
      .empty              (empty),
      .pop                (pop),
      .rsp_target_level   (rsp_target_level),
      .rsp_target_changed (rsp_target_changed),
      .rsp_active_source  (rsp_active_source),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // send one request, with an occasional idle burst ahead of it
   task automatic send_event(logic [2:0] op, logic [6:0] num, logic [13:0] val);
      int gap;
      if (allow_idle && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 5);
         @(negedge clock);
         push <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      push       <= 1'b1;
      req_op     <= op;
      req_number <= num;
      req_value  <= val;
      do @(posedge clock); while (full);
      sb.note_request(op, num, val);
   endtask

   // stop sending and wait until every response has come back
   task automatic drain_results();
      @(negedge clock);
      push <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(mcsm_pkg::csr_index_type idx, logic [7:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // random event, mostly aimed at the source currently in effect
   task automatic pick_event(output logic [2:0] op, output logic [6:0] num,
                             output logic [13:0] val);
      int unsigned r;
      logic [7:0]  src;
      r   = $urandom_range(0, 99);
      src = sb.source_now;
      // small note pool so note offs hit held slots
      num = ($urandom_range(0, 3) != 0) ? 7'($urandom_range(0, 7))
                                        : 7'($urandom_range(0, 127));
      if (r < 8) begin
         op = 3'($urandom_range(mcsm_pkg::OP_OTHER, OP_UNUSED_B));
      end else if (r < 22) begin
         op = mcsm_pkg::OP_NOTE_OFF;
      end else if (r < 80 && !sb.learning) begin
         if (src < mcsm_pkg::SRC_PRESSURE) begin
            op  = mcsm_pkg::OP_CONTROLLER;
            num = src[6:0];
         end else if (src == mcsm_pkg::SRC_PRESSURE) begin
            op = ($urandom_range(0, 9) < 7) ? mcsm_pkg::OP_POLY : mcsm_pkg::OP_PRESSURE;
         end else if (src == mcsm_pkg::SRC_PITCH) begin
            op = mcsm_pkg::OP_PITCH;
         end else begin
            op = 3'($urandom_range(mcsm_pkg::OP_CONTROLLER, mcsm_pkg::OP_PITCH));
         end
      end else begin
         op  = 3'($urandom_range(mcsm_pkg::OP_CONTROLLER, mcsm_pkg::OP_PITCH));
         num = 7'($urandom_range(0, 127));
      end
      r = $urandom_range(0, 9);
      if (op == mcsm_pkg::OP_PITCH) begin
         if (r < 2) val = ($urandom_range(0, 1) != 0) ? 14'd16383 : 14'd0;
         else val = 14'($urandom);
      end else if (r < 7) begin
         val = 14'($urandom_range(0, 127));
      end else if (r < 8) begin
         val = ($urandom_range(0, 1) != 0) ? 14'd127 : 14'd0;
      end else begin
         val = 14'($urandom);
      end
   endtask

   // response side: pop with random stall bursts
   initial begin
      int stall_left;
      stall_left = 0;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            pop <= 1'b0;
            stall_left--;
         end else if (allow_idle && $urandom_range(0, 7) == 0) begin
            pop <= 1'b0;
            stall_left = $urandom_range(0, 4);
         end else begin
            pop <= 1'b1;
         end
         @(posedge clock);
         if (pop && !empty)
            sb.check_result(rsp_target_level, rsp_target_changed, rsp_active_source);
      end
   end

   // main sequence
   initial begin
      logic [2:0]  op;
      logic [6:0]  num;
      logic [13:0] val;
      logic [7:0]  src_pick;
      int          events_sent;
      int          phase_len;
      int          first_reg;
      int          reg_idx;
      events_sent = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset source is controller 1: scaling, saturation, unmatched events
      send_event(mcsm_pkg::OP_CONTROLLER, 7'd1, 14'd0);
      send_event(mcsm_pkg::OP_CONTROLLER, 7'd1, 14'd127);
      send_event(mcsm_pkg::OP_CONTROLLER, 7'd1, 14'd16383);
      send_event(mcsm_pkg::OP_CONTROLLER, 7'd0, 14'd64);
      send_event(mcsm_pkg::OP_PRESSURE, 7'd0, 14'd100);
      send_event(mcsm_pkg::OP_POLY, 7'd127, 14'd90);
      send_event(mcsm_pkg::OP_PITCH, 7'd127, 14'd16383);
      send_event(mcsm_pkg::OP_NOTE_OFF, 7'd127, 14'd0);
      send_event(mcsm_pkg::OP_OTHER, 7'd127, 14'd16383);
      send_event(OP_UNUSED_A, 7'd0, 14'd0);
      send_event(OP_UNUSED_B, 7'h55, 14'h2AAA);

      // aftertouch source, inverted: slot max, note off, saturation
      drain_results();
      write_reg(mcsm_pkg::CSR_SOURCE_SELECT, mcsm_pkg::SRC_PRESSURE);
      write_reg(mcsm_pkg::CSR_INVERT_OUTPUT, 8'd1);
      send_event(mcsm_pkg::OP_POLY, 7'd0, 14'd127);
      send_event(mcsm_pkg::OP_POLY, 7'd127, 14'd16383);
      send_event(mcsm_pkg::OP_NOTE_OFF, 7'd0, 14'd0);
      send_event(mcsm_pkg::OP_POLY, 7'd127, 14'd5);
      send_event(mcsm_pkg::OP_PRESSURE, 7'd0, 14'd200);
      send_event(mcsm_pkg::OP_NOTE_OFF, 7'd127, 14'd0);
      send_event(mcsm_pkg::OP_CONTROLLER, 7'd127, 14'd60);

      // source out of range matches nothing
      drain_results();
      write_reg(mcsm_pkg::CSR_SOURCE_SELECT, 8'd200);
      write_reg(mcsm_pkg::CSR_INVERT_OUTPUT, 8'd0);
      write_reg(mcsm_pkg::CSR_LEARN_ON_START, 8'd0);
      send_event(mcsm_pkg::OP_CONTROLLER, 7'd127, 14'd127);
      send_event(mcsm_pkg::OP_PITCH, 7'd0, 14'd8192);

      // learn: note off and other events leave it armed
      drain_results();
      write_reg(mcsm_pkg::CSR_LEARN_ON_START, 8'd1);
      send_event(mcsm_pkg::OP_NOTE_OFF, 7'd3, 14'd0);
      send_event(mcsm_pkg::OP_OTHER, 7'd3, 14'd0);
      send_event(mcsm_pkg::OP_CONTROLLER, 7'd127, 14'd127);
      drain_results();
      write_reg(mcsm_pkg::CSR_LEARN_ON_START, 8'd1);
      send_event(mcsm_pkg::OP_PITCH, 7'd0, 14'd0);
      drain_results();
      write_reg(mcsm_pkg::CSR_LEARN_ON_START, 8'd1);
      send_event(mcsm_pkg::OP_POLY, 7'd5, 14'd64);

      // random phases, each with fresh register settings
      while (events_sent < RANDOM_EVENTS) begin
         drain_results();
         case ($urandom_range(0, 9))
            0:       src_pick = 8'd0;
            1:       src_pick = 8'd127;
            2:       src_pick = 8'($urandom_range(130, 255));
            3, 4:    src_pick = mcsm_pkg::SRC_PRESSURE;
            5, 6:    src_pick = mcsm_pkg::SRC_PITCH;
            default: src_pick = 8'($urandom_range(0, 127));
         endcase
         first_reg = $urandom_range(0, 2);
         for (int k = 0; k < 3; k++) begin
            reg_idx = (first_reg + k) % 3;
            if (reg_idx == int'(mcsm_pkg::CSR_SOURCE_SELECT))
               write_reg(mcsm_pkg::CSR_SOURCE_SELECT, src_pick);
            else if (reg_idx == int'(mcsm_pkg::CSR_INVERT_OUTPUT))
               write_reg(mcsm_pkg::CSR_INVERT_OUTPUT, 8'($urandom_range(0, 1)));
            else
               write_reg(mcsm_pkg::CSR_LEARN_ON_START, 8'($urandom_range(0, 1)));
         end
         phase_len = $urandom_range(20, 120);
         for (int k = 0; k < phase_len && events_sent < RANDOM_EVENTS; k++) begin
            if (events_sent >= QUIET_FROM) allow_idle = 1'b0;
            pick_event(op, num, val);
            send_event(op, num, val);
            events_sent++;
         end
      end

      drain_results();
      repeat (LATENCY_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule

// File: files.f
+incdir+rtl
rtl/mcsm_pkg.sv
rtl/mcsm_front.sv
rtl/mcsm_back.sv
rtl/midi_controller_source_mapper.sv
bench/tb_midi_controller_source_mapper.sv
